### sv/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by every module of the block.
package dq_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int REPLY_WIDTH        = 32;
   localparam int CMD_QUEUE_DEPTH    = 2;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_FRONT      = 3'd2,
      OP_BACK       = 3'd3,
      OP_SIZE       = 3'd4,
      OP_EMPTY      = 3'd5,
      OP_POP_FRONT  = 3'd6,
      OP_POP_BACK   = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      K_PUSH = 2'd0,
      K_READ = 2'd1,
      K_SIZE = 2'd2,
      K_TEST = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic                    at_front;
      logic                    pop;
      logic [REPLY_WIDTH-1:0]  value;
   } cmd_type;

endpackage

### sv/double_ended_queue.sv
// Double-ended queue over a ring buffer of DEPTH words.
//
// Input: an item (req_opcode, req_push_value) is taken at a rising edge
// with start high and busy low. Opcodes: push back, push front, front,
// back, size, empty test, pop front, pop back.
// Output: one result per item except a successful push. rsp_strobe is high
// for one cycle with rsp_reply and rsp_status; the receiver cannot stall.
// Status ok, empty (reads/pops on an empty queue answer -1), or full (a
// push on a full queue is dropped and answers 0).
//
// An accepted item is written into the command queue; the execution stage
// takes it from there and registers its result, which raises rsp_strobe.
// Throughput: one item per cycle. The execution stage updates head and
// count and issues one memory access per cycle; reads come back from the
// registered memory port in the next cycle. busy rises only if the
// two-entry command queue fills, which steady traffic never causes.
//
// Reset (synchronous) empties the queue: head and count clear, the command
// queue drains. Storage is not cleared; only live entries are ever read.
// Depends on dq_pkg, dq_front, dq_cmd_queue and dq_back.
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_opcode,
   input  logic signed [REPLY_WIDTH-1:0] req_push_value,
   output logic                          rsp_strobe,
   output logic signed [REPLY_WIDTH-1:0] rsp_reply,
   output logic [1:0]                    rsp_status
);

   cmd_type                 front_cmd, back_cmd;
   logic                    front_push;
   logic                    queue_full, queue_empty;
   logic                    back_take;
   logic [REPLY_WIDTH-1:0]  reply_bits;

   dq_front u_front (
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .queue_full     (queue_full),
      .cmd_push       (front_push),
      .cmd            (front_cmd)
   );

   dq_cmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (front_push),
      .wr_cmd (front_cmd),
      .rd_en  (back_take),
      .full   (queue_full),
      .empty  (queue_empty),
      .rd_cmd (back_cmd)
   );

   dq_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!queue_empty),
      .cmd        (back_cmd),
      .cmd_take   (back_take),
      .rsp_strobe (rsp_strobe),
      .rsp_reply  (reply_bits),
      .rsp_status (rsp_status)
   );

   assign rsp_reply = signed'(reply_bits);

endmodule

### sv/dq_front.sv
// Command intake: accepts items and decodes the opcode into a command.
// Depends on dq_pkg; feeds dq_cmd_queue.
module dq_front
   import dq_pkg::*;
(
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_opcode,
   input  logic [REPLY_WIDTH-1:0] req_push_value,
   input  logic                   queue_full,
   output logic                   cmd_push,
   output cmd_type                cmd
);

   opcode_type op;

   assign op       = opcode_type'(req_opcode);
   assign busy     = queue_full;
   assign cmd_push = start && !queue_full;

   always_comb begin
      cmd.value    = req_push_value;
      cmd.at_front = 1'b0;
      cmd.pop      = 1'b0;
      cmd.kind     = K_PUSH;
      unique case (op)
         OP_PUSH_BACK: begin
            cmd.kind = K_PUSH;
         end
         OP_PUSH_FRONT: begin
            cmd.kind     = K_PUSH;
            cmd.at_front = 1'b1;
         end
         OP_FRONT: begin
            cmd.kind     = K_READ;
            cmd.at_front = 1'b1;
         end
         OP_BACK: begin
            cmd.kind = K_READ;
         end
         OP_SIZE: begin
            cmd.kind = K_SIZE;
         end
         OP_EMPTY: begin
            cmd.kind = K_TEST;
         end
         OP_POP_FRONT: begin
            cmd.kind     = K_READ;
            cmd.at_front = 1'b1;
            cmd.pop      = 1'b1;
         end
         OP_POP_BACK: begin
            cmd.kind = K_READ;
            cmd.pop  = 1'b1;
         end
      endcase
   end

endmodule

### sv/dq_cmd_queue.sv
// Short command queue between intake and execution.
// Depends on dq_pkg for the command type and its depth.
module dq_cmd_queue
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_cmd,
   input  logic    rd_en,
   output logic    full,
   output logic    empty,
   output cmd_type rd_cmd
);

   localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type         entry_ff [CMD_QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   fill_ff, fill_in;
   logic            do_wr, do_rd;

   assign full   = (fill_ff == NW'(CMD_QUEUE_DEPTH));
   assign empty  = (fill_ff == '0);
   assign rd_cmd = entry_ff[rd_ptr_ff];
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

### sv/dq_back.sv
// Execution side: ring buffer storage, head pointer, element count and
// the registered result stage. Depends on dq_pkg.
module dq_back
   import dq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  cmd_type                cmd,
   output logic                   cmd_take,
   output logic                   rsp_strobe,
   output logic [REPLY_WIDTH-1:0] rsp_reply,
   output logic [1:0]             rsp_status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [DATA_WIDTH-1:0] element_store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_mem_ff, rsp_mem_in;
   logic [REPLY_WIDTH-1:0] rsp_reply_ff, rsp_reply_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   is_empty, is_full;
   logic [SW-1:0]          tail_sum, back_sum;
   logic [AW-1:0]          tail_pos, back_pos;
   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic signed [63:0]     push_ext, rd_ext;

   assign cmd_take = cmd_valid;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(DEPTH));

   // slot past the last element, and the last element itself
   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign back_sum = tail_sum - SW'(1);
   assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
   assign back_pos = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

   assign push_ext = 64'(signed'(cmd.value));
   assign wr_data  = push_ext[DATA_WIDTH-1:0];
   assign rd_ext   = 64'(signed'(rd_data_ff));

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_pos;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      rsp_valid_in  = 1'b0;
      rsp_mem_in    = 1'b0;
      rsp_reply_in  = '0;
      rsp_status_in = ST_OK;
      if (cmd_valid) begin
         unique case (cmd.kind)
            K_PUSH: begin
               if (is_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (cmd.at_front) begin
                     head_in = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
                     wr_addr = head_in;
                  end
               end
            end
            K_READ: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_reply_in  = '1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  rsp_mem_in = 1'b1;
                  rd_addr    = cmd.at_front ? head_ff : back_pos;
                  if (cmd.pop) begin
                     count_in = count_ff - CW'(1);
                     if (cmd.at_front) begin
                        head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
                     end
                  end
               end
            end
            K_SIZE: begin
               rsp_valid_in = 1'b1;
               rsp_reply_in = REPLY_WIDTH'(count_ff);
            end
            K_TEST: begin
               rsp_valid_in = 1'b1;
               rsp_reply_in = REPLY_WIDTH'(is_empty);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mem_ff    <= rsp_mem_in;
      rsp_reply_ff  <= rsp_reply_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         element_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= element_store_ff[rd_addr];
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_reply  = rsp_mem_ff ? rd_ext[REPLY_WIDTH-1:0] : rsp_reply_ff;
   assign rsp_status = rsp_status_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd.kind == K_PUSH && !is_full) |=>
         (count_ff == $past(count_ff) + CW'(1)) && !rsp_strobe)
      else $error("accepted push did not add one element");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd.kind == K_READ && cmd.pop && !is_empty) |=>
         (count_ff == $past(count_ff) - CW'(1)) && rsp_strobe && rsp_status == ST_OK)
      else $error("pop did not remove one element");

   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd.kind == K_READ && is_empty) |=>
         rsp_strobe && rsp_status == ST_EMPTY && $stable(count_ff) && $stable(head_ff))
      else $error("read on empty queue misreported");
`endif

endmodule

### tb/sv/dq_checker.sv
// Scoreboard for the double-ended queue: watches both channels, keeps its own ring buffer,
// predicts each reply and compares it with the one the block returns.
// Depends on dq_pkg for opcode and status codes.
module dq_checker
   import dq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [2:0]                    req_opcode,
   input  logic signed [REPLY_WIDTH-1:0] req_push_value,
   input  logic                          rsp_strobe,
   input  logic signed [REPLY_WIDTH-1:0] rsp_reply,
   input  logic [1:0]                    rsp_status,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IW = $clog2(DEPTH);

   typedef struct {
      logic [REPLY_WIDTH-1:0] reply;
      status_type             status;
   } reply_type;

   reply_type             expected_replies[$];
   logic [DATA_WIDTH-1:0] ring [DEPTH];
   logic [IW-1:0]         head;
   logic [IW:0]           level;

   initial begin
      fail_count = 0;
      pending    = 0;
      head       = '0;
      level      = '0;
   end

   function automatic int wrap(int i);
      return (i >= DEPTH) ? i - DEPTH : i;
   endfunction

   // stored word is sign-extended from DATA_WIDTH, then cut to the reply width
   function automatic logic [REPLY_WIDTH-1:0] widen(logic [DATA_WIDTH-1:0] w);
      logic signed [63:0] ext;
      ext = signed'(w);
      return ext[REPLY_WIDTH-1:0];
   endfunction

   function automatic void expect_reply(logic [REPLY_WIDTH-1:0] reply, status_type status);
      reply_type r;
      r.reply  = reply;
      r.status = status;
      expected_replies.insert(expected_replies.size(), r);
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic predict_reply(opcode_type op, logic signed [REPLY_WIDTH-1:0] word);
      logic signed [63:0] wide;
      int                 pos;
      wide = word;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (int'(level) >= DEPTH) begin
               expect_reply('0, ST_FULL);
            end else begin
               if (op == OP_PUSH_BACK) begin
                  pos = wrap(int'(head) + int'(level));
               end else begin
                  head = (head == 0) ? IW'(DEPTH - 1) : head - 1'b1;
                  pos = int'(head);
               end
               ring[pos] = wide[DATA_WIDTH-1:0];
               level = level + 1'b1;
            end
         end
         OP_FRONT, OP_POP_FRONT, OP_BACK, OP_POP_BACK: begin
            if (level == 0) begin
               expect_reply('1, ST_EMPTY);
            end else begin
               if (op == OP_FRONT || op == OP_POP_FRONT) pos = int'(head);
               else pos = wrap(int'(head) + int'(level) - 1);
               expect_reply(widen(ring[pos]), ST_OK);
               if (op == OP_POP_FRONT) head = IW'(wrap(int'(head) + 1));
               if (op == OP_POP_FRONT || op == OP_POP_BACK) level = level - 1'b1;
            end
         end
         OP_SIZE:
            expect_reply(REPLY_WIDTH'(level), ST_OK);
         default:
            expect_reply((level == 0) ? REPLY_WIDTH'(1) : REPLY_WIDTH'(0), ST_OK);
      endcase
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         expected_replies.delete();
         head  = '0;
         level = '0;
      end else begin
         // compare first: a reply leaving now belongs to an earlier item
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("unexpected reply %h status %0d", rsp_reply,
                                         rsp_status));
            end else begin
               want = expected_replies[0];
               expected_replies.delete(0);
               if (rsp_reply !== want.reply)
                  report_mismatch($sformatf("reply %h, want %h", rsp_reply, want.reply));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_status,
                                            want.status));
            end
         end
         if (start && !busy)
            predict_reply(opcode_type'(req_opcode), req_push_value);
      end
      pending = expected_replies.size();
   end

endmodule

### tb/sv/tb_double_ended_queue.sv
// Top of the double-ended queue testbench: clock, reset, command stimulus and verdict.
// Depends on dq_pkg, double_ended_queue and dq_checker.
module tb_double_ended_queue
   import dq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = DEPTH_DEFAULT;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [2:0]                    req_opcode;
   logic signed [REPLY_WIDTH-1:0] req_push_value;
   logic                          rsp_strobe;
   logic signed [REPLY_WIDTH-1:0] rsp_reply;
   logic [1:0]                    rsp_status;
   int                            fail_count;
   int                            pending;

   bit idle_on;
   int level;
   int random_sent;

   double_ended_queue #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH_DEFAULT)) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_reply      (rsp_reply),
      .rsp_status     (rsp_status)
   );

   dq_checker #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH_DEFAULT)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_reply      (rsp_reply),
      .rsp_status     (rsp_status),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [REPLY_WIDTH-1:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(opcode_type op, logic [REPLY_WIDTH-1:0] word);
      int gap;
      bit took;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 13);
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_push_value <= word;
      // busy only moves at rising edges, so its value now holds at the next one
      do begin
         took = !busy;
         @(negedge clock);
      end while (!took);
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: if (level < DEPTH) level++;
         OP_POP_FRONT, OP_POP_BACK:   if (level > 0) level--;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic send_random(int mode);
      opcode_type op;
      case (mode)
         1:       op = ($urandom_range(0, 9) < 7) ? opcode_type'($urandom_range(0, 1))
                                                  : opcode_type'($urandom_range(2, 7));
         2:       op = ($urandom_range(0, 9) < 6) ? opcode_type'($urandom_range(6, 7))
                                                  : opcode_type'($urandom_range(0, 5));
         default: op = opcode_type'($urandom_range(0, 7));
      endcase
      send_item(op, rand_word());
   endtask

   // walk the queue to full, push into the full queue, then drain past empty
   task automatic fill_and_drain();
      while (level < DEPTH) send_item(opcode_type'($urandom_range(0, 1)), rand_word());
      repeat ($urandom_range(3, 5)) send_item(opcode_type'($urandom_range(0, 1)), rand_word());
      send_item(OP_SIZE, rand_word());
      send_item(OP_EMPTY, rand_word());
      send_item(OP_FRONT, rand_word());
      send_item(OP_BACK, rand_word());
      send_item(OP_POP_BACK, rand_word());
      send_item(OP_PUSH_FRONT, rand_word());
      send_item(OP_PUSH_BACK, rand_word());
      while (level > 0) begin
         if ($urandom_range(0, 7) == 0) send_item(opcode_type'($urandom_range(2, 5)), rand_word());
         else send_item(opcode_type'($urandom_range(6, 7)), rand_word());
      end
      send_item(OP_POP_FRONT, rand_word());
      send_item(OP_POP_BACK, rand_word());
   endtask

   initial begin
      int burst;
      int mode;
      bit filled;
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_PUSH_BACK;
      req_push_value = '0;
      idle_on        = 1'b1;
      level          = 0;
      random_sent    = 0;
      filled         = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every read and pop on an empty queue, size and empty test included
      send_item(OP_SIZE, '0);
      send_item(OP_EMPTY, '1);
      send_item(OP_FRONT, '0);
      send_item(OP_BACK, '1);
      send_item(OP_POP_FRONT, '0);
      send_item(OP_POP_BACK, '1);
      // push front from head zero wraps to the top of the ring
      send_item(OP_PUSH_FRONT, 32'h8000_0000);
      send_item(OP_PUSH_BACK, 32'h7FFF_FFFF);
      send_item(OP_PUSH_BACK, '0);
      send_item(OP_PUSH_FRONT, '1);
      send_item(OP_FRONT, '0);
      send_item(OP_BACK, '0);
      send_item(OP_SIZE, '0);
      send_item(OP_EMPTY, '0);
      send_item(OP_POP_BACK, '0);
      send_item(OP_POP_FRONT, '0);
      send_item(OP_POP_BACK, '0);
      send_item(OP_POP_FRONT, '0);
      send_item(OP_POP_FRONT, '0);
      send_item(OP_PUSH_BACK, 32'h5555_5555);
      send_item(OP_PUSH_FRONT, 32'hAAAA_AAAA);
      send_item(OP_EMPTY, '0);
      send_item(OP_POP_FRONT, '0);
      send_item(OP_POP_FRONT, '0);
      wait_drained();

      while (random_sent < 500) begin
         if (!filled && random_sent >= 250) begin
            fill_and_drain();
            wait_drained();
            filled = 1'b1;
         end
         if (random_sent >= 400) idle_on = 1'b0;
         burst = $urandom_range(10, 40);
         case ($urandom_range(0, 9))
            0, 1:    mode = 1;
            2, 3:    mode = 2;
            default: mode = 0;
         endcase
         repeat (burst) send_random(mode);
         random_sent += burst;
      end
      start <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
